// ===== hw/rtl/sorted_stream_merge_core_assert.svh =====
// Assertion macros for the sorted stream merge core.
`ifndef SORTED_STREAM_MERGE_CORE_ASSERT_SVH
`define SORTED_STREAM_MERGE_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SSM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define SSM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("assertion failed: next-cycle implication");
`else
`define SSM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define SSM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== hw/rtl/ssm_pkg.sv =====
// Shared types and codes for the sorted stream merge core.
`timescale 1ns / 1ps
package ssm_pkg;

	localparam int VALUE_W = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Input field codes
	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_CLOSE = 1'b1;
	localparam logic SRC_A     = 1'b0;
	localparam logic SRC_B     = 1'b1;

	// Error codes on the result channel
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_FULL   = 2'd1;
	localparam logic [1:0] ERR_CLOSED = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH_A,
		OP_PUSH_B,
		OP_CLOSE_A,
		OP_CLOSE_B
	} op_t;

	typedef struct packed {
		op_t    op;
		value_t value;
	} cmd_t;

	typedef struct packed {
		value_t     value;
		logic       has_value;
		logic       last;
		logic [1:0] error;
	} res_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} bst_t;

endpackage

// ===== hw/rtl/ssm_front.sv =====
// Front end: accepts input transfers, decodes them into commands, queues them.
`timescale 1ns / 1ps
module ssm_front import ssm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic   action,
	input  logic   source,
	input  value_t value,
	output logic   q_valid,
	input  logic   q_ready,
	output cmd_t   q_cmd
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_in;
	logic       push;
	logic       pop;

	// Classify the incoming item
	always_comb begin
		cmd_in.value = value;
		unique case ({action, source})
			{ACT_PUSH, SRC_A}:  cmd_in.op = OP_PUSH_A;
			{ACT_PUSH, SRC_B}:  cmd_in.op = OP_PUSH_B;
			{ACT_CLOSE, SRC_A}: cmd_in.op = OP_CLOSE_A;
			default:            cmd_in.op = OP_CLOSE_B;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = rd_ptr_q ? ent_q[1] : ent_q[0];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Two-entry command queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			if (wr_ptr_q) ent_q[1] <= cmd_in;
			else ent_q[0] <= cmd_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== hw/rtl/ssm_back.sv =====
// Back end: list buffers, merge sequencer and output register.
`timescale 1ns / 1ps
module ssm_back import ssm_pkg::*; #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	value_t mem_a [BUFFER_DEPTH];
	value_t mem_b [BUFFER_DEPTH];
	value_t rd_a_q, rd_b_q;

	bst_t          state_q, state_n;
	logic [AW-1:0] a_head_q, a_head_n, a_tail_q, a_tail_n;
	logic [AW-1:0] b_head_q, b_head_n, b_tail_q, b_tail_n;
	logic [CW-1:0] a_cnt_q, a_cnt_n, b_cnt_q, b_cnt_n;
	logic          a_closed_q, a_closed_n, b_closed_q, b_closed_n;
	logic          out_valid_q;
	res_t          out_res_q;
	res_t          res_n;
	logic          emit, rearm, we_a, we_b, slot_ok;
	logic          both, a_first, take_a, take_b;

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx);
		return (idx == LAST_IDX) ? '0 : idx + 1'b1;
	endfunction

	assign slot_ok   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// Head selection: on equal heads B goes first
	assign both    = (a_cnt_q != '0) && (b_cnt_q != '0);
	assign a_first = (rd_a_q < rd_b_q);
	assign take_a  = both ? a_first : ((a_cnt_q != '0) && b_closed_q);
	assign take_b  = both ? !a_first : ((b_cnt_q != '0) && a_closed_q);

	// Sequencer next state and result
	always_comb begin
		state_n    = state_q;
		a_head_n   = a_head_q;
		a_tail_n   = a_tail_q;
		a_cnt_n    = a_cnt_q;
		a_closed_n = a_closed_q;
		b_head_n   = b_head_q;
		b_tail_n   = b_tail_q;
		b_cnt_n    = b_cnt_q;
		b_closed_n = b_closed_q;
		we_a       = 1'b0;
		we_b       = 1'b0;
		emit       = 1'b0;
		rearm      = 1'b0;
		res_n      = '0;
		cmd_ready  = (state_q == ST_IDLE) && slot_ok;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && slot_ok) begin
					unique case (cmd.op)
						OP_PUSH_A: begin
							if (a_closed_q) begin
								emit        = 1'b1;
								res_n.error = ERR_CLOSED;
							end else if (a_cnt_q == FULL_CNT) begin
								emit        = 1'b1;
								res_n.error = ERR_FULL;
							end else begin
								we_a     = 1'b1;
								a_tail_n = adv(a_tail_q);
								a_cnt_n  = a_cnt_q + ONE_CNT;
								state_n  = ST_DRAIN;
							end
						end
						OP_PUSH_B: begin
							if (b_closed_q) begin
								emit        = 1'b1;
								res_n.error = ERR_CLOSED;
							end else if (b_cnt_q == FULL_CNT) begin
								emit        = 1'b1;
								res_n.error = ERR_FULL;
							end else begin
								we_b     = 1'b1;
								b_tail_n = adv(b_tail_q);
								b_cnt_n  = b_cnt_q + ONE_CNT;
								state_n  = ST_DRAIN;
							end
						end
						OP_CLOSE_A: begin
							a_closed_n = 1'b1;
							state_n    = ST_DRAIN;
						end
						default: begin
							b_closed_n = 1'b1;
							state_n    = ST_DRAIN;
						end
					endcase
				end
			end
			default: begin
				// One merged element per cycle while the output slot is free, until no rule applies
				if (slot_ok) begin
					if (take_a) begin
						emit            = 1'b1;
						res_n.value     = rd_a_q;
						res_n.has_value = 1'b1;
						a_head_n        = adv(a_head_q);
						a_cnt_n         = a_cnt_q - ONE_CNT;
						if (a_closed_q && b_closed_q && a_cnt_q == ONE_CNT
								&& b_cnt_q == '0) begin
							res_n.last = 1'b1;
							rearm      = 1'b1;
							state_n    = ST_IDLE;
						end
					end else if (take_b) begin
						emit            = 1'b1;
						res_n.value     = rd_b_q;
						res_n.has_value = 1'b1;
						b_head_n        = adv(b_head_q);
						b_cnt_n         = b_cnt_q - ONE_CNT;
						if (a_closed_q && b_closed_q && b_cnt_q == ONE_CNT
								&& a_cnt_q == '0) begin
							res_n.last = 1'b1;
							rearm      = 1'b1;
							state_n    = ST_IDLE;
						end
					end else begin
						// Both closed and empty with nothing sent: end marker
						if (a_closed_q && b_closed_q && a_cnt_q == '0 && b_cnt_q == '0) begin
							emit       = 1'b1;
							res_n.last = 1'b1;
							rearm      = 1'b1;
						end
						state_n = ST_IDLE;
					end
				end
			end
		endcase
		if (rearm) begin
			a_head_n   = '0;
			a_tail_n   = '0;
			a_cnt_n    = '0;
			a_closed_n = 1'b0;
			b_head_n   = '0;
			b_tail_n   = '0;
			b_cnt_n    = '0;
			b_closed_n = 1'b0;
		end
	end

	// Buffers; read data always tracks the next head, bypassing a write to it
	always_ff @(posedge clk) begin
		if (we_a) mem_a[a_tail_q] <= cmd.value;
		if (we_b) mem_b[b_tail_q] <= cmd.value;
		rd_a_q <= (we_a && a_tail_q == a_head_n) ? cmd.value : mem_a[a_head_n];
		rd_b_q <= (we_b && b_tail_q == b_head_n) ? cmd.value : mem_b[b_head_n];
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (emit) out_res_q <= res_n;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_head_q    <= '0;
			a_tail_q    <= '0;
			a_cnt_q     <= '0;
			a_closed_q  <= 1'b0;
			b_head_q    <= '0;
			b_tail_q    <= '0;
			b_cnt_q     <= '0;
			b_closed_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			a_head_q   <= a_head_n;
			a_tail_q   <= a_tail_n;
			a_cnt_q    <= a_cnt_n;
			a_closed_q <= a_closed_n;
			b_head_q   <= b_head_n;
			b_tail_q   <= b_tail_n;
			b_cnt_q    <= b_cnt_n;
			b_closed_q <= b_closed_n;
			if (slot_ok) out_valid_q <= emit;
		end
	end

endmodule

// ===== hw/rtl/sorted_stream_merge_core.sv =====
// Timing: a transfer is registered in the front-end queue; once the back end takes it, an error
// result shows in the next cycle, while a merged element or end marker passes through the drain
// state and then the output register. The back end takes no new command while it drains: the
// single-result sequencer sends merged elements from the registered heads until no rule applies.
// Reset: arst_n clears queue, counters, close flags and output valid; buffer contents are not
// cleared, an entry is read only after it is written.
`timescale 1ns / 1ps
`include "sorted_stream_merge_core_assert.svh"
module sorted_stream_merge_core import ssm_pkg::*; #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic       source,
	input  value_t     value,
	output logic       out_valid,
	input  logic       out_ready,
	output value_t     value_res,
	output logic       has_value,
	output logic       last,
	output logic [1:0] error
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	res_t res;

	ssm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.source   (source),
		.value    (value),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd)
	);

	ssm_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign value_res = res.value;
	assign has_value = res.has_value;
	assign last      = res.last;
	assign error     = res.error;

	// An accepted transfer is waiting in the queue on the next cycle
	`SSM_ASSERT_NEXT(a_in_to_queue, clk, arst_n, in_valid && in_ready, q_valid)
	// A stalled command stays queued
	`SSM_ASSERT_NEXT(a_queue_hold, clk, arst_n, q_valid && !q_ready, q_valid)
	// End of sequence never carries an error
	`SSM_ASSERT_IMPLIES(a_last_clean, clk, arst_n, out_valid && last, error == ERR_NONE)

endmodule
